>>> sv/lffd_pkg.sv
// Package for the length-field frame deframer.
// Holds result kinds, register indexes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lffd_pkg;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_NEGATIVE  = 3'd2,
    KIND_BELOW_HDR = 3'd3,
    KIND_STRIP     = 3'd4,
    KIND_TOO_LONG  = 3'd5
  } kind_t;

  localparam logic [2:0] REG_MAX_LEN   = 3'd0;
  localparam logic [2:0] REG_LF_OFFSET = 3'd1;
  localparam logic [2:0] REG_LF_SIZE   = 3'd2;
  localparam logic [2:0] REG_ADJUST    = 3'd3;
  localparam logic [2:0] REG_STRIP     = 3'd4;
  localparam logic [2:0] REG_CHECKSUM  = 3'd5;

  localparam int CFG_DATA_W = 31;
  localparam int LEN_W      = 34;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_REPLAY = 2'd1,
    SRC_BODY   = 2'd2
  } emit_src_t;

  typedef struct packed {
    logic      col_accept;
    logic      lf_req;
    logic      lf_acc;
    logic      calc;
    logic      cmp;
    logic      rp_init;
    logic      rp_req;
    logic      rp_step;
    logic      body_init;
    logic      body_accept;
    logic      disc_load;
    logic      disc_dec;
    logic      clr;
    logic      emit;
    kind_t     emit_kind;
    emit_src_t emit_src;
  } lffd_cmd_t;

  typedef struct packed {
    logic col_done;
    logic lf_more;
    logic neg;
    logic lt_h;
    logic eq_h;
    logic gt_h;
    logic gt_max;
    logic strip_err;
    logic empty;
    logic rp_more;
    logic body_pay;
    logic body_done;
    logic disc_one;
    logic out_free;
  } lffd_status_t;

endpackage
`default_nettype wire

>>> sv/lffd_datapath.sv
// Datapath of the deframer: configuration registers, header memory, counters,
// length arithmetic and the output register. Depends on lffd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lffd_datapath import lffd_pkg::*; #(
  parameter int HEADER_MAX = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]            data_byte,
  input  wire lffd_cmd_t             cmd,
  output lffd_status_t               st,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [2:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic                       last_in_frame,
  output logic [31:0]                reported_length
);

  localparam int AW    = (HEADER_MAX > 1) ? $clog2(HEADER_MAX) : 1;
  localparam int CNT_W = $clog2(HEADER_MAX + 31);

  logic [30:0] max_len;
  logic [3:0]  lf_off;
  logic [3:0]  lf_size;
  logic [16:0] adj;
  logic [15:0] strip;
  logic [3:0]  cs;

  logic [7:0]  mem [HEADER_MAX];
  logic [7:0]  rd_q;

  logic [LEN_W-1:0]        bytes_seen;
  logic [CNT_W-1:0]        hdr;
  logic [CNT_W-1:0]        lf_idx;
  logic [31:0]             v;
  logic signed [LEN_W-1:0] len_l;
  logic signed [LEN_W-1:0] p_len;
  logic signed [LEN_W-1:0] p_m1;
  logic [LEN_W-1:0]        discard;
  logic [15:0]             pos;
  logic                    f_neg, f_lt_h, f_eq_h, f_gt_h, f_gt_max, f_strip, f_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= 31'd65536;
      lf_off  <= 4'd0;
      lf_size <= 4'd4;
      adj     <= 17'd0;
      strip   <= 16'd0;
      cs      <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LEN:   max_len <= cfg_data;
        REG_LF_OFFSET: lf_off  <= cfg_data[3:0];
        REG_LF_SIZE:   lf_size <= cfg_data[3:0];
        REG_ADJUST:    adj     <= cfg_data[16:0];
        REG_STRIP:     strip   <= cfg_data[15:0];
        REG_CHECKSUM:  cs      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Header end clamped to one byte at least and to the memory depth.
  logic [CNT_W-1:0] e_raw, e_eff, col_next, lf_end;
  always_comb begin
    e_raw = CNT_W'(lf_off) + CNT_W'(lf_size);
    if (e_raw == '0) e_eff = CNT_W'(1);
    else if (e_raw > CNT_W'(HEADER_MAX)) e_eff = CNT_W'(HEADER_MAX);
    else e_eff = e_raw;
    col_next = bytes_seen[CNT_W-1:0] + CNT_W'(1);
    lf_end   = e_raw;
  end

  logic signed [LEN_W-1:0] h_s, cs_s, strip_s, bs_s, body_p, pos_s;
  always_comb begin
    h_s     = {{(LEN_W-CNT_W){1'b0}}, hdr};
    cs_s    = {{(LEN_W-4){1'b0}}, cs};
    strip_s = {{(LEN_W-16){1'b0}}, strip};
    bs_s    = bytes_seen;
    pos_s   = {{(LEN_W-16){1'b0}}, pos};
    body_p  = len_l - cs_s;
  end

  logic rp_last, body_last;
  assign rp_last   = (pos_s == p_m1);
  assign body_last = (bs_s + LEN_W'(1) == body_p);

  always_comb begin
    st.col_done  = (col_next >= e_eff);
    st.lf_more   = (lf_idx < lf_end) && (lf_idx < hdr) && (lf_idx < CNT_W'(HEADER_MAX));
    st.neg       = f_neg;
    st.lt_h      = f_lt_h;
    st.eq_h      = f_eq_h;
    st.gt_h      = f_gt_h;
    st.gt_max    = f_gt_max;
    st.strip_err = f_strip;
    st.empty     = f_empty;
    st.rp_more   = (pos_s < p_len) && (pos_s < h_s) && (pos < 16'(HEADER_MAX));
    st.body_pay  = (bs_s >= strip_s) && (bs_s < body_p);
    st.body_done = (bs_s + LEN_W'(1) >= len_l);
    st.disc_one  = (discard == LEN_W'(1));
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.col_accept && (bytes_seen < LEN_W'(HEADER_MAX))) begin
      mem[bytes_seen[AW-1:0]] <= data_byte;
    end
    if (cmd.lf_req || cmd.rp_req) begin
      rd_q <= mem[cmd.lf_req ? lf_idx[AW-1:0] : pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (cmd.clr) begin
      bytes_seen <= '0;
    end else if (cmd.col_accept) begin
      bytes_seen <= bytes_seen + LEN_W'(1);
    end else if (cmd.body_init) begin
      bytes_seen <= LEN_W'(hdr);
    end else if (cmd.body_accept) begin
      bytes_seen <= st.body_done ? '0 : bytes_seen + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_accept && st.col_done) begin
      hdr    <= col_next;
      lf_idx <= CNT_W'(lf_off);
      v      <= '0;
    end
    if (cmd.lf_acc) begin
      v      <= {v[23:0], rd_q};
      lf_idx <= lf_idx + CNT_W'(1);
    end
    if (cmd.calc) begin
      len_l <= $signed({2'b00, v}) + $signed({{(LEN_W-17){adj[16]}}, adj}) + h_s;
    end
    if (cmd.cmp) begin
      f_neg    <= v[31];
      f_lt_h   <= (len_l < h_s);
      f_eq_h   <= (len_l == h_s);
      f_gt_h   <= (len_l > h_s);
      f_gt_max <= (len_l > $signed({3'b000, max_len}));
      f_strip  <= ($signed({{(LEN_W-17){1'b0}}, {1'b0, strip} + {13'd0, cs}}) > len_l);
      p_len    <= len_l - cs_s;
      p_m1     <= len_l - cs_s - LEN_W'(1);
      f_empty  <= (len_l - cs_s == strip_s);
    end
    if (cmd.rp_init) pos <= strip;
    if (cmd.rp_step) pos <= pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discard <= '0;
    end else if (cmd.disc_load) begin
      discard <= len_l - h_s;
    end else if (cmd.disc_dec && (discard != '0)) begin
      discard <= discard - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind        <= cmd.emit_kind;
      reported_length <= (cmd.emit_kind == KIND_TOO_LONG) ? len_l[31:0] : 32'd0;
      case (cmd.emit_src)
        SRC_REPLAY: begin
          out_byte      <= rd_q;
          last_in_frame <= rp_last;
        end
        SRC_BODY: begin
          out_byte      <= data_byte;
          last_in_frame <= body_last;
        end
        default: begin
          out_byte      <= 8'd0;
          last_in_frame <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lffd_controller.sv
// Controller state machine of the deframer: sequences header collection,
// length field read, decision, header replay, body handling and discards. Uses lffd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lffd_controller import lffd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire lffd_status_t st,
  output lffd_cmd_t         cmd
);

  typedef enum logic [11:0] {
    S_COLLECT  = 12'b000000000001,
    S_LF_REQ   = 12'b000000000010,
    S_LF_ACC   = 12'b000000000100,
    S_CALC     = 12'b000000001000,
    S_CMP      = 12'b000000010000,
    S_DECIDE   = 12'b000000100000,
    S_RP_REQ   = 12'b000001000000,
    S_RP_EMIT  = 12'b000010000000,
    S_FINISH   = 12'b000100000000,
    S_BODY     = 12'b001000000000,
    S_TOOLONG  = 12'b010000000000,
    S_SKIP     = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_COLLECT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_COLLECT: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.col_accept = 1'b1;
          if (st.col_done) state_next = S_LF_REQ;
        end
      end
      S_LF_REQ: begin
        if (st.lf_more) begin
          cmd.lf_req = 1'b1;
          state_next = S_LF_ACC;
        end else begin
          state_next = S_CALC;
        end
      end
      S_LF_ACC: begin
        cmd.lf_acc = 1'b1;
        state_next = S_LF_REQ;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        // Checks are taken in priority order; errors wait for a free output.
        if (st.neg || st.lt_h) begin
          if (st.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = st.neg ? KIND_NEGATIVE : KIND_BELOW_HDR;
            cmd.clr       = 1'b1;
            state_next    = S_COLLECT;
          end
        end else if (st.gt_max) begin
          if (st.eq_h) begin
            if (st.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_TOO_LONG;
              cmd.clr       = 1'b1;
              state_next    = S_COLLECT;
            end
          end else begin
            cmd.disc_load = 1'b1;
            cmd.clr       = 1'b1;
            state_next    = S_TOOLONG;
          end
        end else if (st.strip_err) begin
          if (st.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_STRIP;
            cmd.clr       = 1'b1;
            cmd.disc_load = st.gt_h;
            state_next    = st.gt_h ? S_SKIP : S_COLLECT;
          end
        end else begin
          cmd.rp_init = 1'b1;
          state_next  = S_RP_REQ;
        end
      end
      S_RP_REQ: begin
        if (st.rp_more) begin
          cmd.rp_req = 1'b1;
          state_next = S_RP_EMIT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_RP_EMIT: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_PAYLOAD;
          cmd.emit_src  = SRC_REPLAY;
          cmd.rp_step   = 1'b1;
          state_next    = S_RP_REQ;
        end
      end
      S_FINISH: begin
        if (!st.empty || st.out_free) begin
          if (st.empty) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_EMPTY;
          end
          if (st.gt_h) begin
            cmd.body_init = 1'b1;
            state_next    = S_BODY;
          end else begin
            cmd.clr    = 1'b1;
            state_next = S_COLLECT;
          end
        end
      end
      S_BODY: begin
        in_ready = st.out_free;
        if (acc) begin
          cmd.body_accept = 1'b1;
          if (st.body_pay) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_PAYLOAD;
            cmd.emit_src  = SRC_BODY;
          end
          if (st.body_done) state_next = S_COLLECT;
        end
      end
      S_TOOLONG: begin
        in_ready = st.out_free;
        if (acc) begin
          cmd.disc_dec = 1'b1;
          if (st.disc_one) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_TOO_LONG;
            cmd.clr       = 1'b1;
            state_next    = S_COLLECT;
          end
        end
      end
      S_SKIP: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.disc_dec = 1'b1;
          if (st.disc_one) begin
            cmd.clr    = 1'b1;
            state_next = S_COLLECT;
          end
        end
      end
      default: state_next = S_COLLECT;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/length_field_frame_deframer.sv
// Top level of the length-field frame deframer: controller plus datapath.
// Depends on lffd_pkg, lffd_controller and lffd_datapath.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    data_byte
//   out      source     out_valid/out_ready  out_kind, out_byte, last_in_frame,
//                                            reported_length
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// Header bytes are taken one per cycle. When a header completes, the length
// field is read from the header memory one byte at a time, each byte first
// requested and then accumulated; the length is then computed, compared and
// judged, and the header payload bytes are replayed before input resumes. Body
// bytes and too-long discards go one per cycle while the output register is free.
// Reset is synchronous and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module length_field_frame_deframer import lffd_pkg::*; #(
  parameter int HEADER_MAX = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic                       last_in_frame,
  output logic [31:0]                reported_length
);

  lffd_cmd_t    cmd;
  lffd_status_t st;

  lffd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lffd_datapath #(.HEADER_MAX(HEADER_MAX)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .data_byte       (data_byte),
    .cmd             (cmd),
    .st              (st),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .last_in_frame   (last_in_frame),
    .reported_length (reported_length)
  );

endmodule
`default_nettype wire

>>> sv/lffd_checker.sv
// Port-level checker for the deframer and its bind to the top level.
// Depends on lffd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lffd_checker import lffd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic        last_in_frame,
  input wire logic [31:0] reported_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("output beat changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind <= KIND_TOO_LONG)
    else $error("unknown result kind");

  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_in_frame |-> out_kind == KIND_PAYLOAD)
    else $error("last mark on a non-payload beat");

  a_len_only_too_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_TOO_LONG |-> reported_length == 32'd0)
    else $error("length reported outside a too-long beat");

  a_byte_only_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_PAYLOAD |-> out_byte == 8'd0)
    else $error("data byte on an error beat");

endmodule

bind length_field_frame_deframer lffd_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_byte        (out_byte),
  .last_in_frame   (last_in_frame),
  .reported_length (reported_length)
);
`default_nettype wire
